### sv/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg: shared types, constants and crc helpers
// Window sizes, crc constants and the request record of the deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

	localparam int WIN_LEN  = 8;
	localparam int HOLD_LEN = WIN_LEN - 1;
	localparam int CRC_SPAN = 6;
	localparam int CRC_BITS = 8 * CRC_SPAN;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_MIN = 8'd1;
	localparam logic [7:0] FC_MAX = 8'd6;

	typedef logic [7:0] byte_t;
	typedef logic [$clog2(WIN_LEN)-1:0] fill_t;

	typedef struct packed {
		logic [2:0]  function_code;
		logic [15:0] address_word;
		logic [15:0] value_word;
	} req_t;

	// bitwise crc over the span, used for elaboration-time constants only
	function automatic logic [15:0] crc16_run(input logic [15:0] init,
		input logic [CRC_BITS-1:0] data);
		logic [15:0] crc;
		crc = init;
		for (int i = 0; i < CRC_SPAN; i++) begin
			crc = crc ^ {8'h00, data[8*i +: 8]};
			for (int k = 0; k < 8; k++) begin
				if (crc[0]) begin
					crc = (crc >> 1) ^ CRC_POLY;
				end else begin
					crc = crc >> 1;
				end
			end
		end
		return crc;
	endfunction

	// contribution of one data bit, with zero start value
	function automatic logic [15:0] crc16_basis(input int idx);
		logic [CRC_BITS-1:0] one_hot;
		one_hot = '0;
		one_hot[idx] = 1'b1;
		return crc16_run(16'h0000, one_hot);
	endfunction

endpackage

### sv/mrd_rx_if.sv
// ----------------------------------------------------------------------------
// mrd_rx_if: received byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
interface mrd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/mrd_req_if.sv
// ----------------------------------------------------------------------------
// mrd_req_if: decoded request channel
// Valid/ready channel carrying one validated request per transfer.
// ----------------------------------------------------------------------------
interface mrd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  function_code;
	logic [15:0] address_word;
	logic [15:0] value_word;

	modport source (output valid, output function_code, output address_word,
		output value_word, input ready);
	modport sink   (input valid, input function_code, input address_word,
		input value_word, output ready);
endinterface

### sv/mrd_frame_check.sv
// ----------------------------------------------------------------------------
// mrd_frame_check: eight-byte frame validation
// Address match, function code range and parallel crc-16 compare.
// ----------------------------------------------------------------------------
module mrd_frame_check import mrd_pkg::*; (
	input  byte_t frame [WIN_LEN],
	input  byte_t slave_address,
	output logic  frame_ok,
	output req_t  req
);

	localparam logic [15:0] CRC_ZERO = crc16_run(CRC_INIT, '0);

	logic [CRC_BITS-1:0] span;
	logic [15:0]         terms [CRC_BITS];
	logic [15:0]         crc;
	logic                addr_ok;
	logic                fc_ok;
	logic                crc_ok;

	always_comb begin
		for (int i = 0; i < CRC_SPAN; i++) begin
			span[8*i +: 8] = frame[i];
		end
	end

	// crc is affine in the data: constant part plus one term per set bit
	for (genvar g = 0; g < CRC_BITS; g++) begin : g_term
		localparam logic [15:0] BASIS = crc16_basis(g);
		assign terms[g] = span[g] ? BASIS : 16'h0000;
	end

	always_comb begin
		crc = CRC_ZERO;
		for (int i = 0; i < CRC_BITS; i++) begin
			crc = crc ^ terms[i];
		end
	end

	assign addr_ok = (frame[0] == slave_address);
	assign fc_ok   = (frame[1] >= FC_MIN) && (frame[1] <= FC_MAX);
	// either byte order is accepted on the wire
	assign crc_ok  = ((frame[6] == crc[7:0]) && (frame[7] == crc[15:8])) ||
	                 ((frame[6] == crc[15:8]) && (frame[7] == crc[7:0]));

	assign frame_ok = addr_ok && fc_ok && crc_ok;

	assign req.function_code = frame[1][2:0];
	assign req.address_word  = {frame[2], frame[3]};
	assign req.value_word    = {frame[4], frame[5]};

endmodule

### sv/modbus_rtu_request_deframer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_deframer: Modbus RTU request deframer
// Finds address/function/crc-valid eight-byte requests in a byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per clock on rx while rx.ready is high and holds the last seven bytes.
// Each byte that completes an eight-byte window is checked in the same cycle
// it is transferred: byte one against the slave address, byte two as
// function code 1..6, and the crc-16 (poly 0xA001, init 0xFFFF) of bytes
// one to six against bytes seven and eight in either byte order. A good
// frame is registered into the result buffer and posted on req, and the window starts empty; a bad
// frame drops its oldest byte and the scan goes on one byte further.
// Rate is one byte per cycle, set by the combinational window check feeding a
// two-entry result buffer; rx.ready falls only while two results sit waiting
// for req.ready. cfg_ready is always high, and slave_address resets to 1.
module modbus_rtu_request_deframer import mrd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mrd_rx_if.sink        rx,
	mrd_req_if.source     req,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_slave_address
);

	// configuration register
	byte_t slave_addr_q;

	// byte window: held bytes, oldest in entry zero
	byte_t hold_q [HOLD_LEN];
	fill_t fill_q;

	// result buffer: main output register plus skid entry
	req_t  out_q;
	logic  out_vld_q;
	req_t  skid_q;
	logic  skid_vld_q;

	byte_t frame [WIN_LEN];
	logic  frame_ok;
	req_t  frame_req;
	logic  in_xfer;
	logic  out_xfer;
	logic  full;
	logic  emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
		end else if (cfg_valid) begin
			slave_addr_q <= cfg_slave_address;
		end
	end

	// no new byte while the skid entry is occupied
	assign rx.ready = !skid_vld_q;
	assign in_xfer  = rx.valid && rx.ready;
	assign out_xfer = out_vld_q && req.ready;
	assign full     = (fill_q == fill_t'(HOLD_LEN));

	// candidate frame: the seven held bytes plus the incoming one
	always_comb begin
		for (int i = 0; i < HOLD_LEN; i++) begin
			frame[i] = hold_q[i];
		end
		frame[WIN_LEN-1] = rx.rx_byte;
	end

	mrd_frame_check u_check (
		.frame         (frame),
		.slave_address (slave_addr_q),
		.frame_ok      (frame_ok),
		.req           (frame_req)
	);

	assign emit = in_xfer && full && frame_ok;

	// window update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_xfer) begin
			if (!full) begin
				fill_q <= fill_q + fill_t'(1);
			end else if (frame_ok) begin
				fill_q <= '0;
			end
		end
	end

	// held bytes carry no reset: only entries below the fill count are read
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (!full) begin
				for (int i = 0; i < HOLD_LEN; i++) begin
					if (fill_q == fill_t'(i)) begin
						hold_q[i] <= rx.rx_byte;
					end
				end
			end else if (!frame_ok) begin
				// slide by one byte
				for (int i = 0; i < HOLD_LEN - 1; i++) begin
					hold_q[i] <= hold_q[i+1];
				end
				hold_q[HOLD_LEN-1] <= rx.rx_byte;
			end
		end
	end

	// result buffer valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_xfer) begin
				skid_vld_q <= 1'b0;
			end
		end else if (emit) begin
			if (out_vld_q && !req.ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_xfer) begin
			out_vld_q <= 1'b0;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_xfer) begin
				out_q <= skid_q;
			end
		end else if (emit) begin
			if (out_vld_q && !req.ready) begin
				skid_q <= frame_req;
			end else begin
				out_q <= frame_req;
			end
		end
	end

	assign req.valid         = out_vld_q;
	assign req.function_code = out_q.function_code;
	assign req.address_word  = out_q.address_word;
	assign req.value_word    = out_q.value_word;

endmodule

### sv/mrd_checker.sv
// ----------------------------------------------------------------------------
// mrd_checker: port-level checks for the deframer
// Concurrent assertions on the deframer ports, bound to the top level.
// ----------------------------------------------------------------------------
module mrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_ready,
	input logic        req_valid,
	input logic        req_ready,
	input logic [2:0]  function_code,
	input logic [15:0] address_word,
	input logic [15:0] value_word
);

	// only validated codes leave the block
	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> (function_code >= 3'd1 && function_code <= 3'd6))
		else $error("function code out of range");

	// rx backpressure only comes from waiting results
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> req_valid)
		else $error("rx stalled with no pending result");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=>
		$stable(function_code) && $stable(address_word) && $stable(value_word))
		else $error("result changed while stalled");

endmodule

bind modbus_rtu_request_deframer mrd_checker u_mrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_ready      (rx.ready),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.function_code (req.function_code),
	.address_word  (req.address_word),
	.value_word    (req.value_word)
);
